### hw/rtl/slfd_pkg.sv
// Shared types and constants for the sync/length frame deframer.
`default_nettype none

package slfd_pkg;

  typedef enum logic [2:0] {
    PhSync    = 3'd0,
    PhLen     = 3'd1,
    PhInv     = 3'd2,
    PhPayload = 3'd3,
    PhTrailer = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadSync  = 3'd1,
    StBadLen   = 3'd2,
    StBadTrail = 3'd3,
    StTooLong  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RegSyncWord    = 2'd0,
    RegTrailerWord = 2'd1,
    RegMaxPayload  = 2'd2
  } reg_idx_e;

  localparam logic [31:0] SyncWordRst    = 32'h434E_5953;
  localparam logic [15:0] TrailerWordRst = 16'h4E45;
  localparam logic [15:0] MaxPayloadRst  = 16'd1022;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [15:0] trailer_word;
    logic [15:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  out_byte;
    logic        frame_end;
    status_e     status;
    logic [15:0] frame_len;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/sync_length_frame_deframer.sv
// Top level of the sync/length/complement frame deframer with its register port.
// Takes one received byte per beat and sustains one byte per cycle while downstream
// takes the result beats; a byte is held in the input register, is parsed, and its
// result (a payload byte or the status beat that closes a frame) is loaded into the
// result register. The input stalls only while the result register holds a beat
// that downstream has not taken. A frame is four sync bytes, a little-endian 32-bit
// length, its complement, the payload and two trailer bytes; any failed check ends
// the frame with an error status and restarts the sync search on the next byte.
`default_nettype none

module sync_length_frame_deframer
  import slfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  out_byte_o,
  output logic             frame_end_o,
  output logic      [2:0]  status_o,
  output logic      [15:0] frame_len_o
);

  cfg_t        cfg_q;
  reg_idx_e    reg_idx;
  logic        wr_en;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        out_vld_q;
  res_t        out_q;
  res_t        res;
  logic        go;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      RegSyncWord:    prdata = cfg_q.sync_word;
      RegTrailerWord: prdata = {16'd0, cfg_q.trailer_word};
      RegMaxPayload:  prdata = {16'd0, cfg_q.max_payload};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word    <= SyncWordRst;
      cfg_q.trailer_word <= TrailerWordRst;
      cfg_q.max_payload  <= MaxPayloadRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSyncWord:    cfg_q.sync_word    <= pwdata;
        RegTrailerWord: cfg_q.trailer_word <= pwdata[15:0];
        RegMaxPayload:  cfg_q.max_payload  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // advance the parser only when the result register can take a beat
  assign go         = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || go;

  slfd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .go_i   (go),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (go) begin
        in_vld_q <= 1'b0;
      end
      if (go && res.valid) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
    if (go && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_q.out_byte;
  assign frame_end_o = out_q.frame_end;
  assign status_o    = out_q.status;
  assign frame_len_o = out_q.frame_len;

endmodule

`default_nettype wire

### hw/rtl/slfd_core.sv
// Frame parser state machine: sync, length, complement, payload and trailer checks.
`default_nettype none

module slfd_core
  import slfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       go_i,
  input  wire logic [7:0] byte_i,
  output res_t            res_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic        mis_q, mis_d;
  logic [31:0] len_q, len_d;
  logic [31:0] inv_q, inv_d;
  logic [15:0] rem_q, rem_d;

  logic        sync_bad;
  logic        trail_bad;
  logic [31:0] inv_new;
  logic        len_bad;
  logic        too_long;
  logic [15:0] rem_next;

  assign sync_bad  = mis_q | (cfg_i.sync_word[pos_q*8 +: 8] != byte_i);
  assign trail_bad = mis_q | (cfg_i.trailer_word[pos_q[0]*8 +: 8] != byte_i);
  assign inv_new   = {byte_i, inv_q[31:8]};
  assign len_bad   = (~len_q) != inv_new;
  assign too_long  = len_q > {16'd0, cfg_i.max_payload};
  assign rem_next  = rem_q - 16'd1;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    mis_d   = mis_q;
    len_d   = len_q;
    inv_d   = inv_q;
    rem_d   = rem_q;
    if (go_i) begin
      unique case (phase_q)
        PhSync: begin
          mis_d = sync_bad;
          if (pos_q == 2'd3) begin
            pos_d = 2'd0;
            if (sync_bad) begin
              mis_d = 1'b0;
            end else begin
              phase_d = PhLen;
            end
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        PhLen: begin
          len_d = {byte_i, len_q[31:8]};
          if (pos_q == 2'd3) begin
            phase_d = PhInv;
            pos_d   = 2'd0;
          end else begin
            pos_d = pos_q + 2'd1;
          end
        end
        PhInv: begin
          inv_d = inv_new;
          if (pos_q != 2'd3) begin
            pos_d = pos_q + 2'd1;
          end else begin
            pos_d = 2'd0;
            mis_d = 1'b0;
            if (len_bad || too_long) begin
              phase_d = PhSync;
            end else begin
              rem_d   = len_q[15:0];
              phase_d = (len_q[15:0] != 16'd0) ? PhPayload : PhTrailer;
            end
          end
        end
        PhPayload: begin
          rem_d = rem_next;
          if (rem_next == 16'd0) begin
            phase_d = PhTrailer;
            pos_d   = 2'd0;
            mis_d   = 1'b0;
          end
        end
        PhTrailer: begin
          if (pos_q != 2'd0) begin
            phase_d = PhSync;
            pos_d   = 2'd0;
            mis_d   = 1'b0;
          end else begin
            mis_d = trail_bad;
            pos_d = 2'd1;
          end
        end
        default: begin
          phase_d = PhSync;
          pos_d   = 2'd0;
          mis_d   = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.status    = StOk;
    unique case (phase_q)
      PhSync: begin
        res_o.valid     = (pos_q == 2'd3) && sync_bad;
        res_o.frame_end = 1'b1;
        res_o.status    = StBadSync;
      end
      PhInv: begin
        res_o.valid     = (pos_q == 2'd3) && (len_bad || too_long);
        res_o.frame_end = 1'b1;
        res_o.status    = len_bad ? StBadLen : StTooLong;
      end
      PhPayload: begin
        res_o.valid    = 1'b1;
        res_o.out_byte = byte_i;
      end
      PhTrailer: begin
        res_o.valid     = pos_q != 2'd0;
        res_o.frame_end = 1'b1;
        res_o.status    = trail_bad ? StBadTrail : StOk;
        res_o.frame_len = trail_bad ? 16'd0 : len_q[15:0];
      end
      default: begin
        res_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync;
      pos_q   <= 2'd0;
      mis_q   <= 1'b0;
      len_q   <= '0;
      inv_q   <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      mis_q   <= mis_d;
      len_q   <= len_d;
      inv_q   <= inv_d;
      rem_q   <= rem_d;
    end
  end

endmodule

`default_nettype wire

### tb/slfd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the frame deframer: follows register writes, predicts result beats, compares.
module slfd_checker
  import slfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [7:0]  out_byte_i,
  input  wire logic        frame_end_i,
  input  wire logic [2:0]  status_i,
  input  wire logic [15:0] frame_len_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  typedef struct packed {
    logic [7:0]  data;
    logic        fend;
    status_e     st;
    logic [15:0] flen;
  } beat_t;

  localparam int MaxPrinted = 40;

  beat_t       expected_q[$];
  logic [31:0] sync_cfg;
  logic [15:0] trail_cfg;
  logic [15:0] max_cfg;
  phase_e      phase_q;
  logic [1:0]  pos_q;
  logic        miss_q;
  logic [31:0] len_q;
  logic [31:0] inv_q;
  logic [15:0] left_q;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count_o++;
    if (fail_count_o <= MaxPrinted) begin
      $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic close_frame(input status_e code);
    expected_q.push_back(beat_t'{data: 8'h00, fend: 1'b1, st: code,
                                 flen: (code == StOk) ? len_q[15:0] : 16'h0000});
    phase_q = PhSync;
    pos_q   = 2'd0;
    miss_q  = 1'b0;
  endtask

  task automatic deframe(input logic [7:0] b);
    logic [7:0] want;
    case (phase_q)
      PhSync: begin
        want = sync_cfg[8*pos_q +: 8];
        if (want != b) miss_q = 1'b1;
        if (pos_q == 2'd3) begin
          if (miss_q) begin
            close_frame(StBadSync);
          end else begin
            phase_q = PhLen;
            pos_q   = 2'd0;
          end
        end else begin
          pos_q++;
        end
      end
      PhLen: begin
        len_q = {b, len_q[31:8]};
        if (pos_q == 2'd3) begin
          phase_q = PhInv;
          pos_q   = 2'd0;
        end else begin
          pos_q++;
        end
      end
      PhInv: begin
        inv_q = {b, inv_q[31:8]};
        if (pos_q != 2'd3) begin
          pos_q++;
        end else begin
          pos_q  = 2'd0;
          miss_q = 1'b0;
          if (~len_q != inv_q) begin
            close_frame(StBadLen);
          end else if (len_q > {16'h0000, max_cfg}) begin
            close_frame(StTooLong);
          end else begin
            left_q  = len_q[15:0];
            phase_q = (left_q == 16'h0000) ? PhTrailer : PhPayload;
          end
        end
      end
      PhPayload: begin
        expected_q.push_back(beat_t'{data: b, fend: 1'b0, st: StOk, flen: 16'h0000});
        left_q--;
        if (left_q == 16'h0000) begin
          phase_q = PhTrailer;
          pos_q   = 2'd0;
          miss_q  = 1'b0;
        end
      end
      PhTrailer: begin
        want = pos_q[0] ? trail_cfg[15:8] : trail_cfg[7:0];
        if (want != b) miss_q = 1'b1;
        if (pos_q != 2'd0) begin
          close_frame(miss_q ? StBadTrail : StOk);
        end else begin
          pos_q = 2'd1;
        end
      end
      default: begin
        phase_q = PhSync;
        pos_q   = 2'd0;
        miss_q  = 1'b0;
      end
    endcase
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t exp_beat;
    if (!rst_ni) begin
      sync_cfg  = SyncWordRst;
      trail_cfg = TrailerWordRst;
      max_cfg   = MaxPayloadRst;
      phase_q   = PhSync;
      pos_q     = 2'd0;
      miss_q    = 1'b0;
      len_q     = 32'h0;
      inv_q     = 32'h0;
      left_q    = 16'h0;
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          report("unexpected beat, status", status_i, frame_end_i);
        end else begin
          exp_beat = expected_q.pop_front();
          if (out_byte_i !== exp_beat.data) report("out_byte", out_byte_i, exp_beat.data);
          if (frame_end_i !== exp_beat.fend) report("frame_end", frame_end_i, exp_beat.fend);
          if (status_i !== exp_beat.st) report("status", status_i, exp_beat.st);
          if (frame_len_i !== exp_beat.flen) report("frame_len", frame_len_i, exp_beat.flen);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          RegSyncWord:    sync_cfg  = pwdata;
          RegTrailerWord: trail_cfg = pwdata[15:0];
          RegMaxPayload:  max_cfg   = pwdata[15:0];
          default:        ;
        endcase
      end
      if (in_valid_i && in_ready_i) deframe(rx_byte_i);
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/tb_sync_length_frame_deframer.sv
`timescale 1ns / 1ps
// Testbench top: drives link bytes and register writes into the deframer and gives the verdict.
module tb_sync_length_frame_deframer;
  import slfd_pkg::*;

  localparam int LongHold   = 300;
  localparam int DrainLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic [2:0]  status_o;
  logic [15:0] frame_len_o;

  int fail_count;
  int pending_beats;
  int beats_checked;

  logic [31:0] sync_cfg;
  logic [15:0] trail_cfg;
  logic [15:0] max_cfg;
  logic [7:0]  link_q[$];
  int          idle_pct;
  int          stall_pct;
  bit          hold_request;
  int          bytes_sent;
  int          frames_built;
  int          settings_run;

  sync_length_frame_deframer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .status_o    (status_o),
    .frame_len_o (frame_len_o)
  );

  slfd_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_i   (out_byte_o),
    .frame_end_i  (frame_end_o),
    .status_i     (status_o),
    .frame_len_i  (frame_len_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats),
    .checked_o    (beats_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Downstream side: random stalls plus one long hold on request.
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegSyncWord:    sync_cfg  = value;
      RegTrailerWord: trail_cfg = value[15:0];
      default:        max_cfg   = value[15:0];
    endcase
  endtask

  task automatic put_word(input logic [31:0] w, input int nbytes);
    for (int i = 0; i < nbytes; i++) link_q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_head(input logic [31:0] syn, input logic [31:0] len,
                          input logic [31:0] inv);
    put_word(syn, 4);
    put_word(len, 4);
    put_word(inv, 4);
    frames_built++;
  endtask

  task automatic build_frame();
    int          kind;
    int          cap;
    logic [31:0] len;
    logic [15:0] trl;
    kind = $urandom_range(99);
    cap  = (max_cfg < 24) ? max_cfg : 24;
    len  = $urandom_range(cap);
    trl  = trail_cfg;
    if (kind < 7) begin
      repeat ($urandom_range(3, 1)) put_word($urandom, 4);
      return;
    end
    if (kind < 14) begin
      put_word($urandom_range(1) ? $urandom : sync_cfg ^ (32'h1 << $urandom_range(31)), 4);
      return;
    end
    if (kind < 21) begin
      put_head(sync_cfg, len, ~len ^ (32'h1 << $urandom_range(31)));
      return;
    end
    if (kind < 28) begin
      if (max_cfg == 16'hFFFF || $urandom_range(1)) len = $urandom | 32'h0001_0000;
      else len = max_cfg + 32'd1;
      put_head(sync_cfg, len, ~len);
      return;
    end
    if (kind < 35) trl = trl ^ (16'h1 << $urandom_range(15));
    else if (kind < 42) len = (max_cfg < 64) ? max_cfg : 64;
    put_head(sync_cfg, len, ~len);
    repeat (len) link_q.push_back(8'($urandom));
    put_word(trl, 2);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic run_phase(input int target, input int idle, input int stall, input bit squeeze);
    int waited;
    idle_pct  = idle;
    stall_pct = stall;
    settings_run++;
    while (link_q.size() < target) build_frame();
    if (squeeze) hold_request = 1'b1;
    while (link_q.size() > 0) send_byte(link_q.pop_front());
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending_beats != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b0;
    bytes_sent   = 0;
    frames_built = 0;
    settings_run = 0;
    sync_cfg     = SyncWordRst;
    trail_cfg    = TrailerWordRst;
    max_cfg      = MaxPayloadRst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset register values.
    put_word(32'h0000_0000, 4);
    put_head(sync_cfg, 32'd0, ~32'd0);
    put_word(trail_cfg, 2);
    put_head(sync_cfg, 32'd2, ~32'd2);
    put_word(16'hFF00, 2);
    put_word(trail_cfg, 2);
    put_head(sync_cfg, 32'd1, ~32'd1 ^ 32'h8000_0000);
    put_head(sync_cfg, 32'd1023, ~32'd1023);
    put_head(sync_cfg, 32'hFFFF_FFFF, 32'h0000_0000);
    put_head(sync_cfg, 32'd0, ~32'd0);
    put_word(trail_cfg ^ 16'h0100, 2);
    put_head(sync_cfg, 32'd1, ~32'd1);
    put_word(32'h5A, 1);
    put_word(trail_cfg ^ 16'h0001, 2);
    run_phase(0, 0, 0, 1'b0);

    reg_write(RegSyncWord, $urandom);
    reg_write(RegTrailerWord, $urandom_range(16'hFFFF));
    reg_write(RegMaxPayload, 32'd40);
    run_phase(130, 0, 0, 1'b1);

    reg_write(RegSyncWord, 32'h0000_0000);
    reg_write(RegTrailerWord, 32'h0000_FFFF);
    reg_write(RegMaxPayload, 32'd0);
    run_phase(90, 88, 0, 1'b0);

    reg_write(RegSyncWord, 32'hFFFF_FFFF);
    reg_write(RegTrailerWord, 32'h0000_0000);
    reg_write(RegMaxPayload, 32'h0000_FFFF);
    run_phase(120, 0, 88, 1'b0);

    reg_write(RegSyncWord, $urandom);
    reg_write(RegTrailerWord, $urandom_range(16'hFFFF));
    reg_write(RegMaxPayload, $urandom_range(30, 1));
    run_phase(120, 13, 13, 1'b0);

    reg_write(RegSyncWord, SyncWordRst);
    reg_write(RegTrailerWord, TrailerWordRst);
    reg_write(RegMaxPayload, 32'd300);
    run_phase(120, 0, 0, 1'b0);

    repeat (8) @(posedge clk_i);
    $display("Covered %0d link bytes, %0d framed headers, %0d register settings.",
             bytes_sent, frames_built, settings_run);
    $display("Checked %0d result beats under idle, stall and a %0d-cycle output hold.",
             beats_checked, LongHold);
    if (pending_beats != 0) $display("%0d expected beats never arrived", pending_beats);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/slfd_pkg.sv
hw/rtl/slfd_core.sv
hw/rtl/sync_length_frame_deframer.sv
tb/slfd_checker.sv
tb/tb_sync_length_frame_deframer.sv
